// ===== design/lfbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared constants and types for the LSB-first bit reader.
package lfbr_pkg;

    // Sizing of the stream buffer and of one read.
    localparam int RING_BYTES    = 32;
    localparam int MAX_READ_BITS = 64;

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 8;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;

    // Derived widths.
    localparam int WIN_BITS = RING_BYTES * 8;
    localparam int HELD_W   = $clog2(RING_BYTES + 1);
    localparam int POS_W    = HELD_W + 3;
    localparam int CMP_W    = (POS_W > COUNT_W) ? POS_W : COUNT_W;
    localparam int TOT_W    = COUNT_W + 1;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SKIP = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WIDE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Work for the back part.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_READ = 2'd2,
        OP_SKIP = 2'd3
    } op_t;

    // One classified item as it travels through the queue.
    typedef struct packed {
        op_t                 op;
        logic [BYTE_W-1:0]   data_byte;
        logic [COUNT_W-1:0]  count;
        logic [POS_W-1:0]    pos;
        logic [STATUS_W-1:0] status;
        logic                fail;
    } desc_t;

endpackage

`default_nettype wire

// ===== design/lfbr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Front part: keeps the buffer fill state, checks each request and
// turns it into a work descriptor for the back part.
module lfbr_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [lfbr_pkg::CMD_W-1:0]     command,
    input  wire logic [lfbr_pkg::BYTE_W-1:0]    byte_in,
    input  wire logic [lfbr_pkg::COUNT_W-1:0]   bit_count,
    output lfbr_pkg::desc_t                     desc
);

    logic [lfbr_pkg::HELD_W-1:0] held_reg;
    logic [lfbr_pkg::HELD_W-1:0] held_next;
    logic [2:0]                  offset_reg;
    logic [2:0]                  offset_next;
    logic                        sticky_reg;
    logic                        sticky_next;

    logic [lfbr_pkg::POS_W-1:0]  avail;
    logic                        short_req;
    logic [lfbr_pkg::TOT_W-1:0]  total;
    logic [lfbr_pkg::HELD_W-1:0] whole;

    // Bits currently buffered and the result of consuming bit_count of them.
    assign avail     = lfbr_pkg::POS_W'({held_reg, 3'b000}) - lfbr_pkg::POS_W'(offset_reg);
    assign short_req = lfbr_pkg::CMP_W'(bit_count) > lfbr_pkg::CMP_W'(avail);
    assign total     = lfbr_pkg::TOT_W'(offset_reg) + lfbr_pkg::TOT_W'(bit_count);
    assign whole     = lfbr_pkg::HELD_W'(total[lfbr_pkg::TOT_W-1:3]);

    // Classify the request and work out the next fill state.
    always_comb
    begin
        held_next      = held_reg;
        offset_next    = offset_reg;
        sticky_next    = sticky_reg;
        desc.op        = lfbr_pkg::OP_NONE;
        desc.data_byte = byte_in;
        desc.count     = bit_count;
        desc.pos       = avail;
        desc.status    = lfbr_pkg::ST_OK;

        case (command)
            lfbr_pkg::CMD_PUSH:
            begin
                if (held_reg >= lfbr_pkg::HELD_W'(lfbr_pkg::RING_BYTES))
                begin
                    desc.status = lfbr_pkg::ST_FULL;
                end
                else
                begin
                    desc.op   = lfbr_pkg::OP_PUSH;
                    held_next = held_reg + lfbr_pkg::HELD_W'(1);
                end
            end
            lfbr_pkg::CMD_READ, lfbr_pkg::CMD_SKIP:
            begin
                if (command == lfbr_pkg::CMD_READ &&
                    lfbr_pkg::TOT_W'(bit_count) > lfbr_pkg::TOT_W'(lfbr_pkg::MAX_READ_BITS))
                begin
                    desc.status = lfbr_pkg::ST_WIDE;
                end
                else if (short_req)
                begin
                    desc.status = lfbr_pkg::ST_SHORT;
                    sticky_next = 1'b1;
                end
                else
                begin
                    desc.op     = (command == lfbr_pkg::CMD_READ) ? lfbr_pkg::OP_READ
                                                                  : lfbr_pkg::OP_SKIP;
                    held_next   = held_reg - whole;
                    offset_next = total[2:0];
                end
            end
            default:
            begin
                desc.op = lfbr_pkg::OP_NONE;
            end
        endcase

        desc.fail = sticky_next;
    end

    // Fill state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            offset_reg <= '0;
            sticky_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg   <= held_next;
            offset_reg <= offset_next;
            sticky_reg <= sticky_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lfbr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Short descriptor queue between the front and back parts.
module lfbr_queue
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire lfbr_pkg::desc_t push_desc,
    input  wire logic    pop,
    output lfbr_pkg::desc_t head_desc,
    output logic         not_empty,
    output logic         full
);

    lfbr_pkg::desc_t             entry_reg [lfbr_pkg::QUEUE_DEPTH];
    logic [lfbr_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [lfbr_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [lfbr_pkg::QPTR_W:0]   fill_reg;
    logic [lfbr_pkg::QPTR_W:0]   fill_next;

    assign head_desc = entry_reg[rd_ptr_reg];
    assign not_empty = (fill_reg != '0);
    assign full      = (fill_reg == (lfbr_pkg::QPTR_W + 1)'(lfbr_pkg::QUEUE_DEPTH));

    // Occupancy after this cycle's transfers.
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (lfbr_pkg::QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (lfbr_pkg::QPTR_W + 1)'(1);
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + lfbr_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + lfbr_pkg::QPTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

// ===== design/lfbr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Back part: holds the buffered bits as a window aligned so that the next
// stream bit sits in bit 0, inserts pushed bytes and extracts or drops bits
// with a barrel shifter, and keeps the result in an output register.
module lfbr_back
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire lfbr_pkg::desc_t                  desc,
    input  wire logic                             desc_valid,
    output logic                                  pop,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [lfbr_pkg::VALUE_W-1:0]          value,
    output logic [lfbr_pkg::STATUS_W-1:0]         status,
    output logic                                  fail_flag
);

    logic [lfbr_pkg::WIN_BITS-1:0] window_reg;
    logic [lfbr_pkg::WIN_BITS-1:0] window_next;
    logic                          out_valid_reg;
    logic [lfbr_pkg::VALUE_W-1:0]  value_reg;
    logic [lfbr_pkg::VALUE_W-1:0]  value_next;
    logic [lfbr_pkg::STATUS_W-1:0] status_reg;
    logic                          fail_reg;
    logic [lfbr_pkg::VALUE_W-1:0]  read_mask;

    // A descriptor is taken whenever the output register is free or drains.
    assign pop = desc_valid && (!out_valid_reg || !out_stall);

    // Mask for the low bit_count bits; a full-width read keeps every bit.
    assign read_mask = lfbr_pkg::VALUE_W'(((lfbr_pkg::VALUE_W + 1)'(1) << desc.count)
                                          - (lfbr_pkg::VALUE_W + 1)'(1));

    // Window update and read value.
    always_comb
    begin
        window_next = window_reg;
        value_next  = '0;
        case (desc.op)
            lfbr_pkg::OP_PUSH:
            begin
                window_next = (window_reg &
                               ~(lfbr_pkg::WIN_BITS'({lfbr_pkg::BYTE_W{1'b1}}) << desc.pos)) |
                              (lfbr_pkg::WIN_BITS'(desc.data_byte) << desc.pos);
            end
            lfbr_pkg::OP_READ:
            begin
                value_next  = window_reg[lfbr_pkg::VALUE_W-1:0] & read_mask;
                window_next = window_reg >> desc.count;
            end
            lfbr_pkg::OP_SKIP:
            begin
                window_next = window_reg >> desc.count;
            end
            default:
            begin
                window_next = window_reg;
            end
        endcase
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Window and result payload; bits above the buffered count are don't-care.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            window_reg <= window_next;
            value_reg  <= value_next;
            status_reg <= desc.status;
            fail_reg   <= desc.fail;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign fail_flag = fail_reg;

endmodule

`default_nettype wire

// ===== design/lsb_first_bit_reader_top.sv =====
// A request is written into the descriptor queue when its input transfers, and its
// result is registered in the back part's output register when the back part takes it.
// The block takes one item per cycle while the output is not stalled; the back
// part's window shifter takes one descriptor each cycle unless a stalled result holds it.
// A four-entry queue lets the input keep flowing during an output stall until it fills.
// Reset clears the fill counters, the sticky fail flag, the queue and the output
// valid; the bit window itself is not reset and is only read where written.
`timescale 1ns / 1ps
`default_nettype none

module lsb_first_bit_reader_top
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [lfbr_pkg::CMD_W-1:0]     command,
    input  wire logic [lfbr_pkg::BYTE_W-1:0]    byte_in,
    input  wire logic [lfbr_pkg::COUNT_W-1:0]   bit_count,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [lfbr_pkg::VALUE_W-1:0]        value,
    output logic [lfbr_pkg::STATUS_W-1:0]       status,
    output logic                                fail_flag
);

    logic            accept;
    logic            q_full;
    logic            q_not_empty;
    logic            q_pop;
    lfbr_pkg::desc_t front_desc;
    lfbr_pkg::desc_t head_desc;

    // Input transfer happens whenever the queue has room.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Request classification.
    lfbr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .byte_in   (byte_in),
        .bit_count (bit_count),
        .desc      (front_desc)
    );

    // Descriptor queue.
    lfbr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_desc (front_desc),
        .pop       (q_pop),
        .head_desc (head_desc),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // Bit extraction and result register.
    lfbr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (head_desc),
        .desc_valid (q_not_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .status     (status),
        .fail_flag  (fail_flag)
    );

endmodule

`default_nettype wire

// ===== design/lfbr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the bit reader.
module lfbr_checker
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic [lfbr_pkg::CMD_W-1:0]     command,
    input  wire logic [lfbr_pkg::BYTE_W-1:0]    byte_in,
    input  wire logic [lfbr_pkg::COUNT_W-1:0]   bit_count,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic [lfbr_pkg::VALUE_W-1:0]   value,
    input  wire logic [lfbr_pkg::STATUS_W-1:0]  status,
    input  wire logic                           fail_flag
);

    logic seen_fail_reg;

    // Remember that a fail flag has been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_fail_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && fail_flag)
        begin
            seen_fail_reg <= 1'b1;
        end
    end

    // Once delivered, the fail flag stays set on every later result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_fail_reg |-> fail_flag)
        else $error("fail flag dropped after being reported");

    // A short request always reports the fail flag with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == lfbr_pkg::ST_SHORT |-> fail_flag)
        else $error("short request without fail flag");

    // Every error result carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != lfbr_pkg::ST_OK |-> value == '0)
        else $error("nonzero value on an error result");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

endmodule

bind lsb_first_bit_reader_top lfbr_checker u_checker (.*);

`default_nettype wire

// ===== sim/lsb_first_bit_reader_top_test.sv =====
`timescale 1ns / 1ps

module lsb_first_bit_reader_top_test;

    import lfbr_pkg::*;

    // Command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 300;

    // One request offered to the block.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BYTE_W-1:0]  data;
        logic [COUNT_W-1:0] count;
    } request_t;

    // One result as the block reports it.
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic                fail;
    } reading_t;

    // How the two sides idle during a phase.
    typedef enum logic [2:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH,
        IDLE_HOLD
    } idle_mode_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    command   = CMD_PUSH;
    logic [BYTE_W-1:0]   byte_in   = '0;
    logic [COUNT_W-1:0]  bit_count = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic                fail_flag;

    idle_mode_t idle_mode = IDLE_NONE;

    request_t pending_requests[$];
    reading_t expected_readings[$];
    int       error_count = 0;
    int       queued_count = 0;
    logic     in_took = 1'b0;

    // Predicted state of the bit reader.
    logic [BYTE_W-1:0] ring_bytes [RING_BYTES];
    logic [4:0]        ring_head = '0;
    logic [HELD_W-1:0] ring_held = '0;
    logic [2:0]        ring_offset = '0;
    logic              ring_sticky = 1'b0;

    // Fill level as seen by the stimulus, used to shape requests.
    int gen_held = 0;
    int gen_offset = 0;

    lsb_first_bit_reader_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .byte_in   (byte_in),
        .bit_count (bit_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .status    (status),
        .fail_flag (fail_flag)
    );

    always #5 clk = ~clk;

    // Work out the result of one accepted request and update the predicted state.
    task automatic predict_reading(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                                   input logic [COUNT_W-1:0] count, output reading_t r);
        int avail;
        int total;
        int pos;
        int slot;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH:
            begin
                if (ring_held >= RING_BYTES)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    ring_bytes[(ring_head + ring_held) % RING_BYTES] = data;
                    ring_held = ring_held + HELD_W'(1);
                end
            end
            CMD_READ, CMD_SKIP:
            begin
                avail = ring_held * 8 - ring_offset;
                if (cmd == CMD_READ && count > MAX_READ_BITS)
                begin
                    r.status = ST_WIDE;
                end
                else if (count > avail)
                begin
                    r.status = ST_SHORT;
                    ring_sticky = 1'b1;
                end
                else
                begin
                    if (cmd == CMD_READ)
                    begin
                        for (int k = 0; k < count; k++)
                        begin
                            pos = ring_offset + k;
                            slot = (ring_head + pos / 8) % RING_BYTES;
                            r.value[k] = ring_bytes[slot][pos % 8];
                        end
                    end
                    total = ring_offset + count;
                    ring_head = 5'((ring_head + total / 8) % RING_BYTES);
                    ring_held = ring_held - HELD_W'(total / 8);
                    ring_offset = 3'(total % 8);
                end
            end
            default:
            begin
            end
        endcase
        r.fail = ring_sticky;
    endtask

    // Queue one request and track the fill level for later choices.
    task automatic add_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                               input logic [COUNT_W-1:0] count);
        int avail;
        avail = gen_held * 8 - gen_offset;
        pending_requests.push_back('{cmd, data, count});
        queued_count++;
        if (cmd == CMD_PUSH)
        begin
            if (gen_held < RING_BYTES)
                gen_held++;
        end
        else if (((cmd == CMD_READ && count <= MAX_READ_BITS) || cmd == CMD_SKIP)
                 && count <= avail)
        begin
            gen_held -= (gen_offset + count) / 8;
            gen_offset = (gen_offset + count) % 8;
        end
    endtask

    // Random requests: pushes, reads and skips that fit, bursts that fill the
    // ring, the ignored command, and some requests that are too wide or too long.
    task automatic add_random_requests(input int count);
        int stop_at;
        int pick;
        int avail;
        int top;
        int n;
        logic [CMD_W-1:0] cmd;
        stop_at = queued_count + count;
        while (queued_count < stop_at)
        begin
            avail = gen_held * 8 - gen_offset;
            pick = $urandom_range(199);
            if (pick < 3)
            begin
                repeat (RING_BYTES + 2)
                    add_request(CMD_PUSH, BYTE_W'($urandom_range(255)),
                                COUNT_W'($urandom_range(255)));
            end
            else if (pick < 10)
            begin
                add_request(CMD_UNUSED, BYTE_W'($urandom_range(255)),
                            COUNT_W'($urandom_range(255)));
            end
            else if (pick < 90 || avail == 0)
            begin
                add_request(CMD_PUSH, BYTE_W'($urandom_range(255)),
                            COUNT_W'($urandom_range(255)));
            end
            else
            begin
                cmd = ($urandom_range(99) < 65) ? CMD_READ : CMD_SKIP;
                top = avail;
                if (cmd == CMD_READ && top > MAX_READ_BITS)
                    top = MAX_READ_BITS;
                if (top > 255)
                    top = 255;
                pick = $urandom_range(99);
                if (pick < 6)
                    n = 0;
                else if (pick < 12 && cmd == CMD_READ)
                    n = $urandom_range(255, MAX_READ_BITS + 1);
                else if (pick < 18 && avail < top + 1 && top < (cmd == CMD_READ ? 64 : 255))
                    n = $urandom_range(cmd == CMD_READ ? MAX_READ_BITS : 255, avail + 1);
                else if (pick < 30)
                    n = top;
                else
                    n = $urandom_range(top, 1);
                add_request(cmd, BYTE_W'($urandom_range(255)), COUNT_W'(n));
            end
        end
    endtask

    // Wait until every request is in and every result is out.
    task automatic wait_drained();
        while (pending_requests.size() > 0 || in_valid || expected_readings.size() > 0)
            @(posedge clk);
    endtask

    // Driver: offer the next request once the current one has been transferred.
    always @(negedge clk)
    begin
        request_t req;
        logic     gap;
        gap = (idle_mode == IDLE_SEND && $urandom_range(99) < 82)
              || (idle_mode == IDLE_BOTH && $urandom_range(99) < 7);
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_took)
        begin
            if (pending_requests.size() > 0 && !gap)
            begin
                req = pending_requests.pop_front();
                command   <= req.cmd;
                byte_in   <= req.data;
                bit_count <= req.count;
                in_valid  <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, including one long hold-off that fills the block.
    always @(negedge clk)
    begin
        int hold_count;
        if (!rst_n)
        begin
            hold_count = 0;
            out_stall <= 1'b0;
        end
        else if (idle_mode == IDLE_HOLD && hold_count < HOLD_CYCLES)
        begin
            hold_count++;
            out_stall <= 1'b1;
        end
        else if (idle_mode == IDLE_RECV)
        begin
            out_stall <= ($urandom_range(99) < 82);
        end
        else if (idle_mode == IDLE_BOTH)
        begin
            out_stall <= ($urandom_range(99) < 7);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: check each result transfer, then predict each request transfer.
    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        reading_t predicted;
        if (!rst_n)
        begin
            in_took = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{value, status, fail_flag};
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, %s %h %s %0d %s %0b",
                             $time, "got value", got.value, "status", got.status,
                             "fail", got.fail);
                    error_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (got.value !== want.value)
                    begin
                        $display("%0t: value mismatch, expected %h, got %h",
                                 $time, want.value, got.value);
                        error_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got.status);
                        error_count++;
                    end
                    if (got.fail !== want.fail)
                    begin
                        $display("%0t: fail_flag mismatch, expected %0b, got %0b",
                                 $time, want.fail, got.fail);
                        error_count++;
                    end
                end
            end
            in_took = in_valid && !in_stall;
            if (in_took)
            begin
                predict_reading(command, byte_in, bit_count, predicted);
                expected_readings.push_back(predicted);
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero-bit requests, too wide before short, the ignored
        // command, extreme bytes, reads across byte edges, and running short.
        idle_mode = IDLE_NONE;
        add_request(CMD_READ, 8'h00, 8'd0);
        add_request(CMD_SKIP, 8'hFF, 8'd0);
        add_request(CMD_READ, 8'h00, 8'd65);
        add_request(CMD_READ, 8'hFF, 8'd255);
        add_request(CMD_UNUSED, 8'hFF, 8'hFF);
        add_request(CMD_PUSH, 8'h00, 8'hFF);
        add_request(CMD_PUSH, 8'hFF, 8'h00);
        add_request(CMD_PUSH, 8'hA5, 8'h00);
        add_request(CMD_PUSH, 8'h5A, 8'h00);
        add_request(CMD_PUSH, 8'h01, 8'h00);
        add_request(CMD_PUSH, 8'h80, 8'h00);
        add_request(CMD_PUSH, 8'hC3, 8'h00);
        add_request(CMD_PUSH, 8'h3C, 8'h00);
        add_request(CMD_PUSH, 8'h96, 8'h00);
        add_request(CMD_READ, 8'h00, 8'd3);
        add_request(CMD_READ, 8'h00, 8'd64);
        add_request(CMD_READ, 8'h00, 8'd5);
        add_request(CMD_READ, 8'h00, 8'd1);
        add_request(CMD_SKIP, 8'h00, 8'd255);
        add_request(CMD_PUSH, 8'h7E, 8'h00);
        add_request(CMD_SKIP, 8'h00, 8'd7);
        add_request(CMD_READ, 8'h00, 8'd1);
        add_request(CMD_READ, 8'h00, 8'd0);
        wait_drained();

        // Random phases under each kind of idling.
        idle_mode = IDLE_NONE;
        add_random_requests(300);
        wait_drained();
        idle_mode = IDLE_SEND;
        add_random_requests(300);
        wait_drained();
        idle_mode = IDLE_RECV;
        add_random_requests(300);
        wait_drained();
        idle_mode = IDLE_BOTH;
        add_random_requests(300);
        wait_drained();
        idle_mode = IDLE_HOLD;
        add_random_requests(60);
        wait_drained();
        idle_mode = IDLE_NONE;
        add_random_requests(240);
        wait_drained();

        // Give any stray result time to show up.
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_readings.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
